/* src/assert_macros.svh */
// Assertion macros used by the top level of the interrupt line table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ILM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

/* src/ilm_pkg.sv */
// Shared types and codes of the interrupt line table.
package ilm_pkg;

    localparam int NUM_LINES_DEF = 64;
    localparam int LINE_W        = 6;
    localparam int OP_W          = 3;
    localparam int CPU_W         = 8;
    localparam int MAP_W         = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int HW_W          = 2;

    localparam logic [OP_W-1:0] OP_RAISE    = 3'd0;
    localparam logic [OP_W-1:0] OP_MASK     = 3'd1;
    localparam logic [OP_W-1:0] OP_UNMASK   = 3'd2;
    localparam logic [OP_W-1:0] OP_ENABLE   = 3'd3;
    localparam logic [OP_W-1:0] OP_DISABLE  = 3'd4;
    localparam logic [OP_W-1:0] OP_SET_DEST = 3'd5;
    localparam logic [OP_W-1:0] OP_QUERY    = 3'd6;

    localparam logic [HW_W-1:0] HW_NONE = 2'd0;
    localparam logic [HW_W-1:0] HW_LOW  = 2'd1;
    localparam logic [HW_W-1:0] HW_FULL = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_MAP = 2'd1;

    typedef struct packed {
        logic             mask;
        logic             pending;
        logic [CPU_W-1:0] dest;
    } t_entry;

    localparam t_entry ENTRY_RESET = '{mask: 1'b1, pending: 1'b0, dest: '0};

endpackage

/* src/ilm_table.sv */
// Entry memory of the interrupt line table with per-entry written flags.
module ilm_table #(
    parameter int NUM_LINES = ilm_pkg::NUM_LINES_DEF,
    parameter int AW        = $clog2(NUM_LINES)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  ilm_pkg::t_entry i_wr_entry,
    output ilm_pkg::t_entry o_rd_entry
);
    import ilm_pkg::*;

    t_entry                 r_mem [NUM_LINES];
    t_entry                 r_rd_data;
    logic [NUM_LINES-1:0]   r_written;
    logic                   r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_entry;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_written <= r_written[i_rd_addr];
            end
        end
    end

    assign o_rd_entry = r_rd_written ? r_rd_data : ENTRY_RESET;

endmodule

/* src/irq_lazy_mask_pending_table.sv */
// Top level of the interrupt line table with lazy masking.
//
// Channel   Direction  Handshake               Word
// command   in         i_start and not o_busy  i_opcode, i_line, i_target_cpu
// result    out        o_done, one cycle       o_deliver .. o_error
// config    in         i_cfg_valid, o_cfg_ready i_cfg_index, i_cfg_data
//
// For each command, the entry is read from the table memory at the accept edge;
// for a valid line it is written back by the edge that registers the result.
// A new command may be accepted in the cycle the result is shown.
// Reset is synchronous and active low; it clears both maps and the written
// flags, so every entry reads as masked, not pending, CPU 0.
// The result cannot be stalled; the config port is always ready.
`include "assert_macros.svh"

module irq_lazy_mask_pending_table #(
    parameter int NUM_LINES = ilm_pkg::NUM_LINES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [ilm_pkg::OP_W-1:0]        i_opcode,
    input  logic [ilm_pkg::LINE_W-1:0]      i_line,
    input  logic [ilm_pkg::CPU_W-1:0]       i_target_cpu,
    output logic                            o_done,
    output logic                            o_deliver,
    output logic                            o_send_eoi,
    output logic                            o_bogus,
    output logic                            o_kept_masked,
    output logic [ilm_pkg::HW_W-1:0]        o_hw_write,
    output logic                            o_masked_now,
    output logic                            o_pending_now,
    output logic [ilm_pkg::CPU_W-1:0]       o_dest_now,
    output logic                            o_error,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ilm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ilm_pkg::MAP_W-1:0]       i_cfg_data
);
    import ilm_pkg::*;

    localparam int AW = $clog2(NUM_LINES);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic               r_state;
    logic [MAP_W-1:0]   r_level_map;
    logic [MAP_W-1:0]   r_valid_map;
    logic [OP_W-1:0]    r_op;
    logic [LINE_W-1:0]  r_line;
    logic [CPU_W-1:0]   r_target;
    logic               r_done;
    logic               r_deliver;
    logic               r_eoi;
    logic               r_bogus;
    logic               r_kept;
    logic [HW_W-1:0]    r_hw;
    t_entry             r_now;
    logic               r_error;

    logic               accept;
    logic               in_table;
    logic               valid;
    logic               level;
    t_entry             cur;
    t_entry             n_entry;
    logic               n_deliver;
    logic               n_eoi;
    logic               n_bogus;
    logic               n_kept;
    logic [HW_W-1:0]    n_hw;

    assign accept      = i_start && (r_state == S_IDLE);
    assign o_busy      = (r_state == S_EXEC);
    assign o_cfg_ready = 1'b1;

    ilm_table #(
        .NUM_LINES (NUM_LINES),
        .AW        (AW)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (i_line[AW-1:0]),
        .i_wr_en    ((r_state == S_EXEC) && valid),
        .i_wr_addr  (r_line[AW-1:0]),
        .i_wr_entry (n_entry),
        .o_rd_entry (cur)
    );

    assign in_table = {1'b0, r_line} < (LINE_W+1)'(NUM_LINES);
    assign valid    = in_table && r_valid_map[r_line];
    assign level    = r_level_map[r_line];

    always_comb begin
        n_entry   = cur;
        n_deliver = 1'b0;
        n_eoi     = 1'b0;
        n_bogus   = 1'b0;
        n_kept    = 1'b0;
        n_hw      = HW_NONE;
        if (valid) begin
            unique case (r_op)
                OP_RAISE: begin
                    n_eoi = 1'b1;
                    if (!level && cur.mask) begin
                        n_entry.pending = 1'b1;
                    end else if (cur.mask) begin
                        n_bogus = 1'b1;
                    end else begin
                        n_entry.mask = 1'b1;
                        n_hw         = level ? HW_LOW : HW_NONE;
                        n_deliver    = 1'b1;
                    end
                end
                OP_MASK: begin
                    n_entry.mask = 1'b1;
                    n_hw         = level ? HW_LOW : HW_NONE;
                end
                OP_UNMASK: begin
                    if (!level && cur.pending) begin
                        n_entry.pending = 1'b0;
                        n_kept          = 1'b1;
                    end else begin
                        n_entry.mask = 1'b0;
                        n_hw         = level ? HW_LOW : HW_NONE;
                    end
                end
                OP_ENABLE: begin
                    n_entry.pending = 1'b0;
                    n_entry.mask    = 1'b0;
                    n_hw            = HW_LOW;
                end
                OP_DISABLE: begin
                    n_entry.pending = 1'b0;
                    n_entry.mask    = 1'b1;
                    n_hw            = HW_LOW;
                end
                OP_SET_DEST: begin
                    if (cur.dest != r_target) begin
                        n_entry.dest = r_target;
                        n_hw         = HW_FULL;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level_map <= '0;
            r_valid_map <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_LEVEL_MAP) begin
                    r_level_map <= i_cfg_data;
                end else if (i_cfg_index == CFG_VALID_MAP) begin
                    r_valid_map <= i_cfg_data;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_opcode;
            r_line   <= i_line;
            r_target <= i_target_cpu;
        end
        if (r_state == S_EXEC) begin
            r_deliver <= n_deliver;
            r_eoi     <= n_eoi;
            r_bogus   <= n_bogus;
            r_kept    <= n_kept;
            r_hw      <= n_hw;
            r_now     <= in_table ? n_entry : '0;
            r_error   <= !valid;
        end
    end

    assign o_done        = r_done;
    assign o_deliver     = r_deliver;
    assign o_send_eoi    = r_eoi;
    assign o_bogus       = r_bogus;
    assign o_kept_masked = r_kept;
    assign o_hw_write    = r_hw;
    assign o_masked_now  = r_now.mask;
    assign o_pending_now = r_now.pending;
    assign o_dest_now    = r_now.dest;
    assign o_error       = r_error;

    `ILM_ASSERT_NEXT(a_accept_busy, accept, o_busy && !o_done)
    `ILM_ASSERT_SAME(a_done_idle, o_done, !o_busy)
    `ILM_ASSERT_SAME(a_error_quiet, o_done && o_error,
        !o_deliver && !o_send_eoi && (o_hw_write == HW_NONE))
    `ILM_ASSERT_SAME(a_deliver_masks, o_done && o_deliver, o_masked_now && o_send_eoi)
    `ILM_ASSERT_SAME(a_bogus_masked, o_done && o_bogus, o_masked_now && !o_deliver)

endmodule
